// ----- rtl/mtkd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtkd_pkg
// Shared types and constants of the MT19937 keystream byte decoder.
// ----------------------------------------------------------------------------
package mtkd_pkg;

  // Generator geometry.
  localparam int STATE_WORDS = 624;
  localparam int MT_OFFSET   = 397;
  localparam int ADDR_W      = $clog2(STATE_WORDS);

  // Generator constants.
  localparam logic [31:0] MT_MATRIX    = 32'h9908_B0DF;
  localparam logic [31:0] MT_INIT_MULT = 32'h6C07_8965;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [31:0] SEED_OFFSET  = 32'd6;

  // Additive key constants.
  localparam logic [7:0] KEY_START   = 8'hC5;
  localparam logic [7:0] STEP_START  = 8'h83;
  localparam logic [7:0] STEP_GROWTH = 8'h53;

  typedef logic [ADDR_W-1:0] addr_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_ADD,
    S_RD_PAIR,
    S_RD_FAR,
    S_TWIST,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic start_seed;
    logic seed_mul;
    logic seed_add;
    logic rd_far;
    logic twist;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seed_last;
    logic out_free;
  } sts_t;

  // MT19937 output tempering.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mtkd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtkd_if
// Valid/ready channels for cipher bytes in and plain bytes out.
// ----------------------------------------------------------------------------
interface mtkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       first_of_buffer;

  modport source(output valid, output cipher_byte, output first_of_buffer, input ready);
  modport sink(input valid, input cipher_byte, input first_of_buffer, output ready);
endinterface

interface mtkd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;

  modport source(output valid, output plain_byte, input ready);
  modport sink(input valid, input plain_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/mtkd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtkd_ctrl
// Sequencer for seeding, per-word twist, and result delivery.
// ----------------------------------------------------------------------------
module mtkd_ctrl
  import mtkd_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  input  wire  in_first,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_first) begin
            cmd.start_seed = 1'b1;
            state_next     = S_SEED_MUL;
          end else begin
            state_next = S_RD_PAIR;
          end
        end
      end
      S_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        cmd.seed_add = 1'b1;
        state_next   = sts.seed_last ? S_RD_PAIR : S_SEED_MUL;
      end
      S_RD_PAIR: begin
        state_next = S_RD_FAR;
      end
      S_RD_FAR: begin
        cmd.rd_far = 1'b1;
        state_next = S_TWIST;
      end
      S_TWIST: begin
        cmd.twist  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/mtkd_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtkd_datapath
// Generator word memory, seeding arithmetic, twist, tempering and key.
// ----------------------------------------------------------------------------
module mtkd_datapath
  import mtkd_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_data,
  input  wire  [7:0]  cipher_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  plain_byte
);

  localparam addr_t LAST_ADDR = addr_t'(STATE_WORDS - 1);

  logic [31:0] mem [STATE_WORDS];
  logic [31:0] rd0_q;
  logic [31:0] rd1_q;

  logic [31:0] buffer_length;
  logic [7:0]  cipher_q;
  logic [31:0] prev;
  logic [31:0] prod;
  addr_t       seed_k;
  addr_t       gen_index;
  logic [31:0] y_q;
  logic [7:0]  res_q;
  logic [7:0]  add_key;
  logic [7:0]  add_step;

  addr_t         next_addr;
  logic [ADDR_W:0] far_sum;
  addr_t         far_addr;
  addr_t         rd0_addr;
  logic [31:0]   seed_val;
  logic [31:0]   seed_word;
  logic [31:0]   twist_word;
  logic [31:0]   tempered;
  logic          wr_en;
  addr_t         wr_addr;
  logic [31:0]   wr_data;

  // Neighbor addresses of the current word, wrapped at the table end.
  assign next_addr = (gen_index == LAST_ADDR) ? '0 : gen_index + addr_t'(1);
  assign far_sum   = {1'b0, gen_index} + (ADDR_W+1)'(MT_OFFSET);
  assign far_addr  = (far_sum >= (ADDR_W+1)'(STATE_WORDS)) ?
                     addr_t'(far_sum - (ADDR_W+1)'(STATE_WORDS)) : addr_t'(far_sum);
  assign rd0_addr  = cmd.rd_far ? far_addr : gen_index;

  // Seeding and twist arithmetic.
  assign seed_val   = buffer_length + SEED_OFFSET;
  assign seed_word  = prod + {{(32-ADDR_W){1'b0}}, seed_k};
  assign twist_word = rd0_q ^ (y_q >> 1) ^ (y_q[0] ? MT_MATRIX : 32'h0);
  assign tempered   = temper(twist_word);

  // Single write port shared by seeding and twist.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = gen_index;
    wr_data = twist_word;
    if (cmd.start_seed) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = seed_val;
    end else if (cmd.seed_add) begin
      wr_en   = 1'b1;
      wr_addr = seed_k;
      wr_data = seed_word;
    end else if (cmd.twist) begin
      wr_en = 1'b1;
    end
  end

  // Generator word memory with two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0_q <= mem[rd0_addr];
    rd1_q <= mem[next_addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cipher_q <= cipher_byte;
    end
    if (cmd.start_seed) begin
      prev <= seed_val;
    end else if (cmd.seed_add) begin
      prev <= seed_word;
    end
    if (cmd.seed_mul) begin
      prod <= (prev ^ (prev >> 30)) * MT_INIT_MULT;
    end
    if (cmd.rd_far) begin
      y_q <= {rd0_q[31], rd1_q[30:0]};
    end
    if (cmd.twist) begin
      res_q <= cipher_q ^ tempered[7:0] ^ add_key;
    end
    if (cmd.out_load) begin
      plain_byte <= res_q;
    end
  end

  // Configuration, counters, key and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= '0;
      seed_k        <= '0;
      gen_index     <= '0;
      add_key       <= KEY_START;
      add_step      <= STEP_START;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_length <= cfg_data;
      end
      if (cmd.start_seed) begin
        seed_k    <= addr_t'(1);
        gen_index <= '0;
        add_key   <= KEY_START;
        add_step  <= STEP_START;
      end else if (cmd.seed_add) begin
        seed_k <= seed_k + addr_t'(1);
      end else if (cmd.twist) begin
        gen_index <= next_addr;
        add_key   <= add_key + add_step;
        add_step  <= add_step + STEP_GROWTH;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status to the controller.
  assign sts.seed_last = (seed_k == LAST_ADDR);
  assign sts.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

// ----- rtl/mt19937_keystream_table_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mt19937_keystream_table_decoder_top
// MT19937 XOR keystream byte decoder with an additive byte key.
// ----------------------------------------------------------------------------
// Channel    Direction  Payload                          Handshake
// byte_in    in         cipher_byte[7:0], first_of_buffer valid/ready
// byte_out   out        plain_byte[7:0]                  valid/ready
// cfg        in         cfg_data[31:0] (buffer_length)   cfg_we, no wait
//
// An accepted byte passes the pair read, far read, twist and output steps,
// set by the two registered memory reads and the per-word twist write,
// before the next byte is accepted. A byte marked first of a buffer first
// seeds: a multiply and an add per word after word 0, via one write port.
// Reset clears control state only; the word memory is valid once seeded.
// A stalled output holds one result while the next byte is accepted and
// worked; the block waits in its final step only if that result is unread.
// ----------------------------------------------------------------------------
module mt19937_keystream_table_decoder_top
  import mtkd_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire   [31:0] cfg_data,
  mtkd_in_if.sink      byte_in,
  mtkd_out_if.source   byte_out
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  mtkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_first (byte_in.first_of_buffer),
    .in_ready (byte_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  mtkd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .cipher_byte (byte_in.cipher_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (byte_out.valid),
    .out_ready   (byte_out.ready),
    .plain_byte  (byte_out.plain_byte)
  );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MT19937 keystream byte decoder. A driver feeds
// cipher bytes from a pending queue, and a receiver takes plain bytes. Both
// sides pause at random between items. A behavioral decoder, which seeds and
// twists its own MT19937 state, predicts every plain byte, and each output
// item is checked against the oldest prediction. The buffer length register
// is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import mtkd_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int HOLD_AT     = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int LONG_BUFFER = 1300;
  localparam int PHASE_BYTES = 120;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       restart;
  } cipher_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;

  mtkd_in_if  byte_in_if();
  mtkd_out_if byte_out_if();

  mt19937_keystream_table_decoder_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .byte_in  (byte_in_if),
    .byte_out (byte_out_if)
  );

  // Pending cipher bytes and predicted plain bytes.
  cipher_item_t pend_q[$];
  logic [7:0]   plain_due[$];

  // Behavioral decoder state.
  logic [31:0] mt_words[STATE_WORDS];
  int unsigned mt_pos;
  logic [7:0]  key_acc;
  logic [7:0]  key_step;
  logic [31:0] length_reg;

  // Handshakes seen at the last rising edge.
  logic in_fire;
  logic out_fire;

  int errors;
  int bytes_done;
  int buffers_seen;
  int settings_done;
  int cycles;

  // Driver and receiver pacing.
  int in_sent;
  int in_gap;
  bit in_burst;
  int out_seen;
  int out_gap;
  bit out_burst;
  int hold_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decodes one byte and advances the keystream state.
  function automatic logic [7:0] decode_byte(input logic [7:0] cb, input logic restart);
    logic [31:0] w;
    logic [31:0] y;
    logic [31:0] v;
    logic [7:0]  plain;
    if (restart) begin
      mt_words[0] = length_reg + SEED_OFFSET;
      for (int k = 1; k < STATE_WORDS; k++) begin
        w = mt_words[k-1];
        mt_words[k] = (w ^ (w >> 30)) * MT_INIT_MULT + 32'(k);
      end
      mt_pos   = STATE_WORDS;
      key_acc  = KEY_START;
      key_step = STEP_START;
    end
    // All words used up: regenerate the whole table.
    if (mt_pos >= STATE_WORDS) begin
      for (int k = 0; k < STATE_WORDS; k++) begin
        y = {mt_words[k][31], mt_words[(k + 1) % STATE_WORDS][30:0]};
        v = mt_words[(k + MT_OFFSET) % STATE_WORDS] ^ (y >> 1);
        if (y[0]) begin
          v = v ^ MT_MATRIX;
        end
        mt_words[k] = v;
      end
      mt_pos = 0;
    end
    w = mt_words[mt_pos];
    mt_pos++;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    plain    = cb ^ w[7:0] ^ key_acc;
    key_acc  = key_acc + key_step;
    key_step = key_step + STEP_GROWTH;
    return plain;
  endfunction

  // Prediction on accepted input items and checking of output items.
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      mt_pos     = STATE_WORDS;
      key_acc    = KEY_START;
      key_step   = STEP_START;
      length_reg = '0;
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      if (cfg_we) begin
        length_reg = cfg_data;
      end
      in_fire  <= byte_in_if.valid && byte_in_if.ready;
      out_fire <= byte_out_if.valid && byte_out_if.ready;
      if (byte_in_if.valid && byte_in_if.ready) begin
        plain_due.push_back(decode_byte(byte_in_if.cipher_byte, byte_in_if.first_of_buffer));
        bytes_done++;
        if (byte_in_if.first_of_buffer) begin
          buffers_seen++;
        end
      end
      if (byte_out_if.valid && byte_out_if.ready) begin
        if (plain_due.size() == 0) begin
          $error("plain_byte: no item expected, actual %02h", byte_out_if.plain_byte);
          errors++;
        end else begin
          want = plain_due.pop_front();
          if (byte_out_if.plain_byte !== want) begin
            $error("plain_byte: expected %02h, actual %02h", want, byte_out_if.plain_byte);
            errors++;
          end
        end
      end
    end
  end

  // Input driver: one item from the pending queue after a random pause.
  always @(negedge clk) begin
    cipher_item_t item;
    if (rst) begin
      byte_in_if.valid           <= 1'b0;
      byte_in_if.cipher_byte     <= '0;
      byte_in_if.first_of_buffer <= 1'b0;
    end else if (!byte_in_if.valid || in_fire) begin
      if (in_fire) begin
        in_sent++;
        if (in_sent % 40 == 0) begin
          in_burst = ($urandom_range(0, 3) == 0);
        end
        in_gap = in_burst ? 0 : $urandom_range(0, 15);
      end
      if (in_gap > 0 || pend_q.size() == 0) begin
        if (in_gap > 0) begin
          in_gap--;
        end
        byte_in_if.valid <= 1'b0;
      end else begin
        item = pend_q.pop_front();
        byte_in_if.valid           <= 1'b1;
        byte_in_if.cipher_byte     <= item.cipher_byte;
        byte_in_if.first_of_buffer <= item.restart;
      end
    end
  end

  // Output receiver: random pause after each item, and one long stall.
  always @(negedge clk) begin
    if (rst) begin
      byte_out_if.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        out_seen++;
        if (out_seen % 40 == 0) begin
          out_burst = ($urandom_range(0, 3) == 0);
        end
        out_gap = out_burst ? 0 : $urandom_range(0, 15);
        if (out_seen == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        byte_out_if.ready <= 1'b0;
      end else begin
        byte_out_if.ready <= 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Waits until every byte is sent and every plain byte has come back.
  task automatic settle();
    while (pend_q.size() != 0 || byte_in_if.valid || plain_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Writes the buffer length register; the block must be idle.
  task automatic write_length(input logic [31:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    settings_done++;
  endtask

  task automatic queue_byte(input logic [7:0] cb, input logic restart);
    pend_q.push_back('{cipher_byte: cb, restart: restart});
  endtask

  // A buffer of random bytes; a noisy one may restart in the middle.
  task automatic queue_buffer(input int len, input bit noisy);
    for (int i = 0; i < len; i++) begin
      queue_byte(8'($urandom), (i == 0) || (noisy && $urandom_range(0, 15) == 0));
    end
  endtask

  initial begin
    int total;
    logic [31:0] lv;
    byte_in_if.valid           = 1'b0;
    byte_in_if.cipher_byte     = '0;
    byte_in_if.first_of_buffer = 1'b0;
    byte_out_if.ready          = 1'b0;
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Length zero: byte extremes, then back-to-back one-byte buffers.
    write_length(32'h0000_0000);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h3C, 1'b1);
    queue_byte(8'hC3, 1'b1);
    settle();

    // All-ones length: the seed wraps around to five.
    write_length(32'hFFFF_FFFF);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    settle();

    // Seed of all ones, then a seed of zero.
    write_length(32'hFFFF_FFF9);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'hFE, 1'b0);
    settle();
    write_length(32'hFFFF_FFFA);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'h80, 1'b0);
    settle();

    // Bytes past the stated length just continue the keystream.
    write_length(32'd5);
    for (int i = 0; i < 10; i++) begin
      queue_byte(8'($urandom), i == 0);
    end
    settle();

    // One long buffer that runs through the word table more than twice.
    write_length($urandom);
    queue_buffer(LONG_BUFFER, 1'b0);
    settle();

    // Short buffers under a mix of length settings.
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 4))
        0: lv = 32'h0000_0000;
        1: lv = 32'hFFFF_FFFF;
        2: lv = 32'($urandom_range(0, 64));
        default: lv = $urandom;
      endcase
      write_length(lv);
      total = 0;
      while (total < PHASE_BYTES) begin
        lv = $urandom_range(1, 40);
        queue_buffer(lv, 1'b1);
        total += lv;
      end
      settle();
    end

    $display("Decoded %0d bytes in %0d buffers under %0d buffer length settings.",
             bytes_done, buffers_seen, settings_done);
    $display("Covered table regeneration, seed wraparound and a long output stall.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mtkd_pkg.sv
rtl/mtkd_if.sv
rtl/mtkd_ctrl.sv
rtl/mtkd_datapath.sv
rtl/mt19937_keystream_table_decoder_top.sv
tb/tb_top.sv
